// ===== design/ps2_mouse_packet_decoder_macros.svh =====
// Assertion macros shared by the PS/2 mouse packet decoder modules.
// Each user module must have ports named aclk and aresetn.
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH

// Checked at every rising edge outside reset.
`define PS2MPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define PS2MPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/ps2mpd_pkg.sv =====
// Package of the PS/2 mouse packet decoder: configuration and report types,
// register indexes and bit positions. Depends on nothing.
`default_nettype none

package ps2mpd_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_IDX_WHEEL = 8'd0;
    localparam logic [7:0] CFG_IDX_XBTN  = 8'd1;

    // Bit positions inside the mouse bytes.
    localparam int SYNC_BIT    = 3;
    localparam int SIGN_X_BIT  = 4;
    localparam int SIGN_Y_BIT  = 5;
    localparam int BTN4_BIT    = 4;
    localparam int BTN5_BIT    = 5;

    typedef struct packed {
        logic wheel_en;
        logic xbtn_en;
    } cfg_t;

    typedef struct packed {
        logic       btn_fifth;
        logic       btn_fourth;
        logic       btn_middle;
        logic       btn_right;
        logic       btn_left;
        logic [8:0] move_wheel;
        logic [8:0] move_y;
        logic [8:0] move_x;
    } report_t;

    // Four-bit wheel code: 0..8 stand for themselves, 9..15 for -7..-1.
    function automatic logic [8:0] wheel_nibble(input logic [3:0] n);
        logic [8:0] r;
        if (n <= 4'd8) begin
            r = {5'b00000, n};
        end else begin
            r = {5'b11111, n};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder: one mouse byte per input beat in, one report beat per packet out.
// Path: the last byte of a packet passes the input register, then the result register, which drives m_tvalid.
// Throughput: one byte per cycle while the result register is not held full by a low m_tready.
// Reset: synchronous, active-low aresetn clears the byte position and both valid flags and
// returns the wheel_en and xbtn_en configuration bits to zero.
// Top level: config registers, input register, result register; uses ps2mpd_frame.
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2_mouse_packet_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Byte channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    // Report channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [8:0] move_x, [17:9] move_y, [26:18] move_wheel,
                                         // [27] btn_left, [28] btn_right, [29] btn_middle,
                                         // [30] btn_fourth, [31] btn_fifth
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic        cfg_data
);

    ps2mpd_pkg::cfg_t    cfg_reg;
    ps2mpd_pkg::report_t rpt;
    ps2mpd_pkg::report_t out_reg;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg;
    logic       rpt_fire;
    logic       advance;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == ps2mpd_pkg::CFG_IDX_WHEEL) cfg_reg.wheel_en <= cfg_data;
            if (cfg_index == ps2mpd_pkg::CFG_IDX_XBTN)  cfg_reg.xbtn_en  <= cfg_data;
        end
    end

    // The held byte moves on unless it finishes a packet while the result
    // register is full and not being drained this cycle.
    assign advance  = in_vld_reg && (!rpt_fire || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    ps2mpd_frame u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_vld (advance),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg_reg),
        .rpt_fire (rpt_fire),
        .rpt      (rpt)
    );

    // Result register: loads a finished report, empties when the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && rpt_fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && rpt_fire) begin
            out_reg <= rpt;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.btn_fifth, out_reg.btn_fourth, out_reg.btn_middle,
                       out_reg.btn_right, out_reg.btn_left, out_reg.move_wheel,
                       out_reg.move_y, out_reg.move_x};

    `PS2MPD_ASSERT(a_stall_cause, (in_vld_reg && !advance) |-> (out_vld_reg && !m_tready),
        "input register stalled without a blocked result")
    `PS2MPD_ASSERT(a_ready_low, !s_tready |-> in_vld_reg,
        "input not ready while the input register is empty")
    `PS2MPD_ASSERT(a_load_free, (advance && rpt_fire) |-> (!out_vld_reg || m_tready),
        "result register overwritten before its beat was taken")

endmodule

`default_nettype wire

// ===== design/ps2mpd_frame.sv =====
// Packet framing of the PS/2 mouse decoder: byte position, stored packet
// bytes and report decode. Depends on ps2mpd_pkg and the assertion macros.
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2mpd_frame (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               byte_vld,   // byte is consumed this cycle
    input  wire logic [7:0]         rx_byte,
    input  wire ps2mpd_pkg::cfg_t   cfg,
    output logic                    rpt_fire,   // this byte completes a packet
    output ps2mpd_pkg::report_t     rpt
);

    localparam logic [1:0] POS_B0 = 2'd0;
    localparam logic [1:0] POS_B1 = 2'd1;
    localparam logic [1:0] POS_B2 = 2'd2;
    localparam logic [1:0] POS_B3 = 2'd3;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic [7:0] b2_val;

    always_comb begin
        pos_next = pos_reg;
        unique case (pos_reg)
            POS_B0: if (rx_byte[ps2mpd_pkg::SYNC_BIT]) pos_next = POS_B1;
            POS_B1: pos_next = POS_B2;
            POS_B2: pos_next = cfg.wheel_en ? POS_B3 : POS_B0;
            POS_B3: pos_next = POS_B0;
            default: pos_next = POS_B0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_B0;
        end else if (byte_vld) begin
            pos_reg <= pos_next;
        end
    end

    // Packet bytes need no reset: each is written before it is used.
    always_ff @(posedge aclk) begin
        if (byte_vld) begin
            if (pos_reg == POS_B0) b0_reg <= rx_byte;
            if (pos_reg == POS_B1) b1_reg <= rx_byte;
            if (pos_reg == POS_B2) b2_reg <= rx_byte;
        end
    end

    assign rpt_fire = (pos_reg == POS_B3) || ((pos_reg == POS_B2) && !cfg.wheel_en);
    assign b2_val   = (pos_reg == POS_B2) ? rx_byte : b2_reg;

    always_comb begin
        rpt.move_x     = {b0_reg[ps2mpd_pkg::SIGN_X_BIT], b1_reg};
        rpt.move_y     = {b0_reg[ps2mpd_pkg::SIGN_Y_BIT], b2_val};
        rpt.btn_left   = b0_reg[0];
        rpt.btn_right  = b0_reg[1];
        rpt.btn_middle = b0_reg[2];
        if (pos_reg == POS_B3) begin
            rpt.move_wheel = cfg.xbtn_en ? ps2mpd_pkg::wheel_nibble(rx_byte[3:0])
                                         : {1'b0, rx_byte};
            rpt.btn_fourth = rx_byte[ps2mpd_pkg::BTN4_BIT];
            rpt.btn_fifth  = rx_byte[ps2mpd_pkg::BTN5_BIT];
        end else begin
            rpt.move_wheel = 9'd0;
            rpt.btn_fourth = 1'b0;
            rpt.btn_fifth  = 1'b0;
        end
    end

    `PS2MPD_ASSERT(a_fire_pos, rpt_fire |-> (pos_reg == POS_B2 || pos_reg == POS_B3),
        "report fired outside the last byte of a packet")
    `PS2MPD_ASSERT(a_sync_kept, (pos_reg == POS_B1) |-> b0_reg[ps2mpd_pkg::SYNC_BIT],
        "packet started on a byte without the sync bit")

endmodule

`default_nettype wire

// ===== tb/ps2mpd_report_checker.sv =====
`timescale 1ns / 100ps
// Report checker for the PS/2 mouse packet decoder: watches the byte, report and
// configuration channels, predicts each report and compares it. Uses ps2mpd_pkg.
module ps2mpd_report_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic        cfg_data,
    output int               mismatches,
    output int               reports_due
);

    ps2mpd_pkg::cfg_t    mode;
    logic [1:0]          byte_pos;
    logic [7:0]          held [0:2];
    ps2mpd_pkg::report_t due_q [$];

    initial begin
        mismatches  = 0;
        reports_due = 0;
    end

    // Advances the packet assembly by one mouse byte; returns 1 with a report
    // when the byte completes a packet.
    function automatic logic take_byte(input logic [7:0] b,
                                       output ps2mpd_pkg::report_t rep);
        logic [3:0] n;
        rep = '0;
        case (byte_pos)
            2'd0: begin
                // A first byte without the sync bit is dropped.
                if (b[ps2mpd_pkg::SYNC_BIT]) begin
                    held[0]  = b;
                    byte_pos = 2'd1;
                end
                return 1'b0;
            end
            2'd1: begin
                held[1]  = b;
                byte_pos = 2'd2;
                return 1'b0;
            end
            2'd2: begin
                held[2] = b;
                if (mode.wheel_en) begin
                    byte_pos = 2'd3;
                    return 1'b0;
                end
                byte_pos = 2'd0;
            end
            default: begin
                byte_pos = 2'd0;
                n = b[3:0];
                if (mode.xbtn_en) begin
                    rep.move_wheel = (n > 4'd8) ? 9'(n) - 9'd16 : 9'(n);
                end else begin
                    rep.move_wheel = {1'b0, b};
                end
                rep.btn_fourth = b[ps2mpd_pkg::BTN4_BIT];
                rep.btn_fifth  = b[ps2mpd_pkg::BTN5_BIT];
            end
        endcase
        rep.move_x     = {held[0][ps2mpd_pkg::SIGN_X_BIT], held[1]};
        rep.move_y     = {held[0][ps2mpd_pkg::SIGN_Y_BIT], held[2]};
        rep.btn_left   = held[0][0];
        rep.btn_right  = held[0][1];
        rep.btn_middle = held[0][2];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [8:0] want_v,
                               input logic [8:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        ps2mpd_pkg::report_t got;
        ps2mpd_pkg::report_t want;
        ps2mpd_pkg::report_t fresh;
        if (!aresetn) begin
            mode     = '0;
            byte_pos = 2'd0;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_q.size() == 0) begin
                    $display("%0t: no report expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = due_q.pop_front();
                    check_field("move_x", want.move_x, got.move_x);
                    check_field("move_y", want.move_y, got.move_y);
                    check_field("move_wheel", want.move_wheel, got.move_wheel);
                    check_field("btn_left", 9'(want.btn_left), 9'(got.btn_left));
                    check_field("btn_right", 9'(want.btn_right), 9'(got.btn_right));
                    check_field("btn_middle", 9'(want.btn_middle), 9'(got.btn_middle));
                    check_field("btn_fourth", 9'(want.btn_fourth), 9'(got.btn_fourth));
                    check_field("btn_fifth", 9'(want.btn_fifth), 9'(got.btn_fifth));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ps2mpd_pkg::CFG_IDX_WHEEL) begin
                    mode.wheel_en = cfg_data;
                end else if (cfg_index == ps2mpd_pkg::CFG_IDX_XBTN) begin
                    mode.xbtn_en = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                if (take_byte(s_tdata, fresh)) begin
                    due_q.insert(due_q.size(), fresh);
                end
            end
        end
        reports_due = due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the PS/2 mouse packet decoder testbench: clock, reset, byte stimulus,
// configuration writes and the verdict. Uses ps2mpd_pkg and ps2mpd_report_checker.
module tb;

    // An index that maps to no register; writes to it must be ignored.
    localparam logic [7:0] CFG_IDX_SPARE = 8'hFF;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Extra quiet cycles that settle() waits once every predicted report is out.
    localparam int DRAIN_CYCLES = 3;
    localparam int PHASE_BYTES  = 200;
    localparam int PHASES       = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic        cfg_data;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int mismatches;
    int reports_due;

    ps2_mouse_packet_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ps2mpd_report_checker rpt_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The report side drops m_tready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hang detection: any accepted beat on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one byte, with random idle cycles in front of it, and returns
    // right after the edge at which the beat was accepted. s_tvalid stays high
    // so that back-to-back bytes follow without a gap.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops the byte stream and waits until every predicted report has been
    // taken, then lets the block sit idle before returning. The pending count
    // is read at the falling edge, clear of the checker's update.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (reports_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers, then the unused index with random data.
    // Only called while the block is settled.
    task automatic configure(input logic wheel, input logic xbtn);
        logic [7:0] idx [0:2];
        logic       val [0:2];
        idx[0] = ps2mpd_pkg::CFG_IDX_WHEEL;
        idx[1] = ps2mpd_pkg::CFG_IDX_XBTN;
        idx[2] = CFG_IDX_SPARE;
        val[0] = wheel;
        val[1] = xbtn;
        val[2] = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // A well-formed packet with random content: the sync bit is forced in the
    // first byte, everything else is free.
    task automatic send_packet(input int len);
        logic [7:0] first;
        first = 8'($urandom_range(255));
        first[ps2mpd_pkg::SYNC_BIT] = 1'b1;
        send_byte(first);
        repeat (len - 1) send_byte(8'($urandom_range(255)));
    endtask

    // Mostly whole packets; the rest are lone random bytes, which either get
    // dropped as a bad first byte or knock the packet framing out of step.
    task automatic random_traffic(input int count, input logic wheel);
        int done_bytes;
        done_bytes = 0;
        while (done_bytes < count) begin
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)));
                done_bytes++;
            end else begin
                send_packet(wheel ? 4 : 3);
                done_bytes += wheel ? 4 : 3;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= ps2mpd_pkg::CFG_IDX_WHEEL;
        cfg_data  <= 1'b0;
        m_tready  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first with the registers at their reset values
        // (three-byte packets). Two bad first bytes are dropped, then packets
        // with all-zero and all-one content.
        send_byte(8'h00);
        send_byte(8'hF7);
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // Wheel byte taken as a plain unsigned value, with both extra buttons.
        settle();
        configure(1'b1, 1'b0);
        send_byte(8'h0F);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);

        // Four-bit wheel codes at both ends of the negative range.
        settle();
        configure(1'b1, 1'b1);
        send_byte(8'h08);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h09);
        send_byte(8'h1C);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h3F);

        // Wheel mode turned off while the fourth byte is awaited: the packet
        // must still complete as a four-byte packet.
        send_byte(8'h08);
        send_byte(8'h01);
        send_byte(8'h02);
        settle();
        configure(1'b0, 1'b1);
        send_byte(8'h27);

        // Wheel mode turned on after the second byte: the third byte no longer
        // ends the packet.
        send_byte(8'h09);
        send_byte(8'h03);
        settle();
        configure(1'b1, 1'b0);
        send_byte(8'h04);
        send_byte(8'h80);

        // Random part: every register combination, every idling style. A
        // partial packet may straddle a phase boundary, which is legal.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            configure(phase[0], phase[1]);
            case ((phase + phase / 4) % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 53;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 53;
                end
                default: begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            random_traffic(PHASE_BYTES / 2, phase[0]);
            // On odd phases the stream pauses until every report is out.
            if (phase[0]) begin
                settle();
            end
            random_traffic(PHASE_BYTES / 2, phase[0]);
        end

        settle();
        if (mismatches == 0 && reports_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
